[design/tleb_pkg.sv]
package tleb_pkg;

	// Line geometry
	localparam int DEPTH      = 32;
	localparam int TOKEN_BITS = 5;
	localparam int POS_BITS   = $clog2(DEPTH + 1);
	localparam int IDX_BITS   = $clog2(DEPTH);

	// Port field widths
	localparam int OP_W    = 3;
	localparam int TOKIN_W = 5;
	localparam int RDIDX_W = 5;
	localparam int RDTOK_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_LEFT   = 3'd0,
		OP_RIGHT  = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_READ   = 3'd4
	} op_t;

	// Edit command broadcast to every cell
	typedef struct packed {
		logic                  ins;
		logic                  del;
		logic [POS_BITS-1:0]   cur;
		logic [POS_BITS-1:0]   cnt;
		logic [TOKEN_BITS-1:0] tok;
	} edit_bus_t;

endpackage

[design/token_line_edit_buffer_core.sv]
// Token line edit buffer with an edit cursor.
// Command channel: drive op, token_in and read_index with start high; the
// transfer happens at a rising edge where start is high and busy is low.
// busy stays low, so a command may be issued in every cycle.
// Ops: cursor left/right (wrapping over 0..fill), insert at the cursor,
// backspace delete before the cursor, read of one slot.
// Result channel: in the cycle after each transfer, done is high for exactly one
// cycle with accepted, cursor_pos, fill_count and read_token. The receiver
// cannot stall; the result is held only until the next transfer.
// Throughput is one command per cycle: every slot is a cell of a row that
// loads its left or right neighbor in parallel, so an insert or delete shifts
// the whole line at the edge that takes the command.
// Reset (arst_n low) clears all slots to zero, cursor and fill to zero, and
// drops done.
module token_line_edit_buffer_core import tleb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [OP_W-1:0]    op,
	input  logic [TOKIN_W-1:0] token_in,
	input  logic [RDIDX_W-1:0] read_index,
	output logic               done,
	output logic               accepted,
	output logic [5:0]         cursor_pos,
	output logic [5:0]         fill_count,
	output logic [RDTOK_W-1:0] read_token
);

	logic                  take;
	logic [POS_BITS-1:0]   cursor_q, cursor_d;
	logic [POS_BITS-1:0]   count_q, count_d;
	logic                  done_q;
	logic                  acc_q, acc_d;
	logic [RDTOK_W-1:0]    rd_q, rd_d;
	logic                  ins_ok, del_ok;
	edit_bus_t             edit;
	logic [TOKEN_BITS-1:0] cell_tok [DEPTH];

	assign busy   = 1'b0;
	assign take   = start && !busy;
	assign ins_ok = count_q < POS_BITS'(DEPTH);
	assign del_ok = cursor_q != '0;

	// Decode the command into cursor and fill updates and the cell broadcast
	always_comb begin
		cursor_d = cursor_q;
		count_d  = count_q;
		acc_d    = 1'b0;
		rd_d     = '0;
		edit.ins = 1'b0;
		edit.del = 1'b0;
		edit.cur = cursor_q;
		edit.cnt = count_q;
		edit.tok = token_in[TOKEN_BITS-1:0];
		case (op)
			OP_LEFT: begin
				cursor_d = (cursor_q == '0) ? count_q : cursor_q - POS_BITS'(1);
				acc_d    = 1'b1;
			end
			OP_RIGHT: begin
				cursor_d = (cursor_q >= count_q) ? '0 : cursor_q + POS_BITS'(1);
				acc_d    = 1'b1;
			end
			OP_INSERT: begin
				if (ins_ok) begin
					edit.ins = take;
					cursor_d = cursor_q + POS_BITS'(1);
					count_d  = count_q + POS_BITS'(1);
					acc_d    = 1'b1;
				end
			end
			OP_DELETE: begin
				if (del_ok) begin
					edit.del = take;
					cursor_d = cursor_q - POS_BITS'(1);
					count_d  = count_q - POS_BITS'(1);
					acc_d    = 1'b1;
				end
			end
			OP_READ: begin
				if ({1'b0, read_index} < (RDIDX_W + 1)'(DEPTH))
					rd_d = RDTOK_W'(cell_tok[read_index[IDX_BITS-1:0]]);
			end
			default: ;
		endcase
	end

	// Row of slot cells, each fed by its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [TOKEN_BITS-1:0] left_tok;
		logic [TOKEN_BITS-1:0] right_tok;
		if (i == 0) begin : g_first
			assign left_tok = '0;
		end else begin : g_left
			assign left_tok = cell_tok[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_tok = '0;
		end else begin : g_right
			assign right_tok = cell_tok[i+1];
		end
		tleb_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.slot      (POS_BITS'(i)),
			.edit      (edit),
			.left_tok  (left_tok),
			.right_tok (right_tok),
			.tok       (cell_tok[i])
		);
	end

	// Advance cursor and fill on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= take;
			if (take) begin
				cursor_q <= cursor_d;
				count_q  <= count_d;
			end
		end
	end

	// Hold result payload for the strobe cycle
	always_ff @(posedge clk) begin
		if (take) begin
			acc_q <= acc_d;
			rd_q  <= rd_d;
		end
	end

	assign done       = done_q;
	assign accepted   = acc_q;
	assign cursor_pos = 6'(cursor_q);
	assign fill_count = 6'(count_q);
	assign read_token = rd_q;

endmodule

[design/tleb_cell.sv]
module tleb_cell import tleb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [POS_BITS-1:0]   slot,
	input  edit_bus_t             edit,
	input  logic [TOKEN_BITS-1:0] left_tok,
	input  logic [TOKEN_BITS-1:0] right_tok,
	output logic [TOKEN_BITS-1:0] tok
);

	logic [TOKEN_BITS-1:0] tok_q;
	logic [TOKEN_BITS-1:0] tok_d;
	logic [POS_BITS-1:0]   slot_up;

	assign slot_up = slot + POS_BITS'(1);

	// Pick own slot's next content: new token, left neighbor, right neighbor or hold
	always_comb begin
		tok_d = tok_q;
		if (edit.ins) begin
			if (slot == edit.cur)
				tok_d = edit.tok;
			else if (slot > edit.cur && slot <= edit.cnt)
				tok_d = left_tok;
		end else if (edit.del) begin
			if (slot_up >= edit.cur && slot_up < edit.cnt)
				tok_d = right_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tok_q <= '0;
		else
			tok_q <= tok_d;
	end

	assign tok = tok_q;

endmodule

[design/tleb_checker.sv]
module tleb_checker import tleb_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [OP_W-1:0]    op,
	input logic               done,
	input logic               accepted,
	input logic [5:0]         cursor_pos,
	input logic [5:0]         fill_count,
	input logic [RDTOK_W-1:0] read_token
);

	// Every transfer yields a result strobe in the next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("transfer without result strobe");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result strobe without transfer");

	// Cursor stays within the held line, fill within the depth
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cursor_pos <= fill_count && fill_count <= 6'(DEPTH)))
		else $error("cursor or fill out of range");

	// Only edit ops may report a change
	a_acc_op: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> ($past(op) == OP_LEFT || $past(op) == OP_RIGHT ||
			$past(op) == OP_INSERT || $past(op) == OP_DELETE))
		else $error("accepted set for non-edit op");

	// Read data appears only for reads
	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		(done && read_token != '0) |-> $past(op) == OP_READ)
		else $error("read data on non-read op");

endmodule

bind token_line_edit_buffer_core tleb_checker u_tleb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.op         (op),
	.done       (done),
	.accepted   (accepted),
	.cursor_pos (cursor_pos),
	.fill_count (fill_count),
	.read_token (read_token)
);
